// ===== src/swm_pkg.sv =====
// Shared constants and types for the sliding-window median filter.
// No dependencies; every other file of the block refers to this package.
package swm_pkg;

    localparam int WINDOW_MAX_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int CFG_WIDTH        = 7;

    localparam logic [CFG_WIDTH-1:0] WINDOW_SIZE_RESET = 7'd3;

    // Per-beat control broadcast to every cell of the sorted row.
    typedef struct packed {
        logic en;     // a sample beat is taken this cycle
        logic flush;  // empty the row before this sample is inserted
        logic full;   // window full: drop the oldest sample while inserting
        logic clear;  // window size rewritten: empty the row now
    } t_cell_ctl;

endpackage

// ===== src/swm_cell.sv =====
// One cell of the sorted window row: holds one sample and its valid bit.
// Uses swm_pkg::t_cell_ctl; talks only to the cells directly above and below.
module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  swm_pkg::t_cell_ctl      i_ctl,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [SAMPLE_WIDTH-1:0] i_old,
    input  logic [SAMPLE_WIDTH-1:0] i_up_val,
    input  logic                    i_up_vld,
    input  logic [SAMPLE_WIDTH-1:0] i_lo_val,
    input  logic                    i_lo_vld,
    input  logic                    i_lo_gt,
    output logic [SAMPLE_WIDTH-1:0] o_val,
    output logic                    o_vld,
    output logic [SAMPLE_WIDTH-1:0] o_a_val,
    output logic                    o_a_vld,
    output logic                    o_gt
);

    logic [SAMPLE_WIDTH-1:0] r_val;
    logic                    r_vld;
    logic [SAMPLE_WIDTH-1:0] n_val;
    logic                    n_vld;
    logic                    vld;
    logic                    ge;

    assign vld   = r_vld & ~i_ctl.flush;
    assign o_val = r_val;
    assign o_vld = vld;

    // Close the gap left by the dropped sample, then compare with the new one.
    assign ge      = i_ctl.full & vld & (r_val >= i_old);
    assign o_a_val = ge ? i_up_val : r_val;
    assign o_a_vld = ge ? i_up_vld : vld;
    assign o_gt    = ~o_a_vld | (o_a_val > i_sample);

    always_comb begin
        if (!o_gt) begin
            n_val = o_a_val;
            n_vld = o_a_vld;
        end else if (i_lo_gt) begin
            n_val = i_lo_val;
            n_vld = i_lo_vld;
        end else begin
            n_val = i_sample;
            n_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_val <= n_val;
        end
    end

endmodule

// ===== src/sliding_window_median_top.sv =====
// Sliding-window median filter: running lower median of the last k samples.
// Uses swm_pkg and a row of swm_cell instances kept in ascending order.
//
// Usage:
//   s_axis: one sample per beat, tdata = sample, tuser = stream start (empties
//   the window before the sample is taken). m_axis: one median per beat.
//   cfg: write the window size k (1..WINDOW_MAX, 0 acts as 1, larger values
//   saturate); a write empties the window. Write only while the block idles.
//   After a stream start or a size write the first k-1 samples give no
//   result; every later sample gives one.
// Timing:
//   One sample per clock unless the output stalls. The sorted row drops the
//   oldest sample and inserts the new one in the cycle of the input beat;
//   each cell only looks at its neighbors. The oldest sample comes from the
//   arrival ring, read into a register ahead of the beat that uses it. The
//   median is picked from the registered row and lands in the output register.
//   When the receiver stalls, the output holds and one more result waits in
//   the row; s_axis_tready then drops until the output moves.
// Reset: empties the window, drops pending results, window size becomes 3.
module sliding_window_median_top #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: [SAMPLE_WIDTH-1:0] sample, rest zero
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // tuser: [0] stream_start
    input  logic                                 s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: [SAMPLE_WIDTH-1:0] median, rest zero
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [swm_pkg::CFG_WIDTH-1:0]        i_cfg_data
);

    localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int KW = $clog2(WINDOW_MAX + 1);
    localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = (KW > swm_pkg::CFG_WIDTH) ? KW : swm_pkg::CFG_WIDTH;

    logic [swm_pkg::CFG_WIDTH-1:0] r_wsize;
    logic [KW-1:0]                 k;
    logic [KW-1:0]                 midx;
    logic [CW-1:0]                 wsize_ext;

    logic [KW-1:0]                 r_fill;
    logic [KW-1:0]                 n_fill;
    logic [KW-1:0]                 fill_eff;
    logic [PW-1:0]                 r_ptr;
    logic [PW-1:0]                 n_ptr;
    logic [PW-1:0]                 ptr_eff;
    logic [PW-1:0]                 rd_ptr;
    logic [KW-1:0]                 ptr_inc;

    logic [SAMPLE_WIDTH-1:0]       ring [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0]       r_old;

    logic                          accept;
    logic                          cfg_wr;
    logic                          full;
    logic                          result;
    logic                          move;
    logic                          r_pend;
    logic                          r_out_vld;
    logic [SAMPLE_WIDTH-1:0]       r_out;
    logic [SAMPLE_WIDTH-1:0]       med;
    logic [SAMPLE_WIDTH-1:0]       sample;

    swm_pkg::t_cell_ctl            ctl;

    logic [SAMPLE_WIDTH-1:0]       c_val   [WINDOW_MAX];
    logic                          c_vld   [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0]       c_a_val [WINDOW_MAX];
    logic                          c_a_vld [WINDOW_MAX];
    logic                          c_gt    [WINDOW_MAX];

    assign sample        = s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign o_cfg_ready   = 1'b1;
    assign cfg_wr        = i_cfg_valid;
    assign move          = r_pend & (~r_out_vld | m_axis_tready);
    assign s_axis_tready = ~r_pend | move;
    assign accept        = s_axis_tvalid & s_axis_tready;

    // Effective window size and median slot.
    assign wsize_ext = CW'(r_wsize);
    always_comb begin
        if (r_wsize == '0) begin
            k = KW'(1);
        end else if (wsize_ext > CW'(WINDOW_MAX)) begin
            k = KW'(WINDOW_MAX);
        end else begin
            k = wsize_ext[KW-1:0];
        end
    end
    assign midx = (k - KW'(1)) >> 1;

    // Fill count and ring pointer.
    assign fill_eff = s_axis_tuser ? '0 : r_fill;
    assign ptr_eff  = s_axis_tuser ? '0 : r_ptr;
    assign full     = (fill_eff == k);
    assign n_fill   = full ? fill_eff : fill_eff + KW'(1);
    assign result   = (n_fill == k);
    assign ptr_inc  = KW'(ptr_eff) + KW'(1);
    assign n_ptr    = (ptr_inc >= k) ? '0 : ptr_inc[PW-1:0];

    always_comb begin
        if (cfg_wr) begin
            rd_ptr = '0;
        end else if (accept) begin
            rd_ptr = n_ptr;
        end else begin
            rd_ptr = r_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= swm_pkg::WINDOW_SIZE_RESET;
            r_fill  <= '0;
            r_ptr   <= '0;
        end else if (cfg_wr) begin
            r_wsize <= i_cfg_data;
            r_fill  <= '0;
            r_ptr   <= '0;
        end else if (accept) begin
            r_fill  <= n_fill;
            r_ptr   <= n_ptr;
        end
    end

    // Arrival ring; read the next oldest slot into r_old ahead of its use.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            ring[ptr_eff] <= sample;
        end
        if (accept && ptr_eff == rd_ptr) begin
            r_old <= sample;
        end else begin
            r_old <= ring[rd_ptr];
        end
    end

    // Sorted cell row.
    assign ctl.en    = accept;
    assign ctl.flush = s_axis_tuser;
    assign ctl.full  = full;
    assign ctl.clear = cfg_wr;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        logic [SAMPLE_WIDTH-1:0] up_val;
        logic                    up_vld;
        logic [SAMPLE_WIDTH-1:0] lo_val;
        logic                    lo_vld;
        logic                    lo_gt;

        if (g == WINDOW_MAX - 1) begin : g_top
            assign up_val = '0;
            assign up_vld = 1'b0;
        end else begin : g_mid
            assign up_val = c_val[g+1];
            assign up_vld = c_vld[g+1];
        end

        if (g == 0) begin : g_bot
            assign lo_val = '0;
            assign lo_vld = 1'b0;
            assign lo_gt  = 1'b0;
        end else begin : g_chain
            assign lo_val = c_a_val[g-1];
            assign lo_vld = c_a_vld[g-1];
            assign lo_gt  = c_gt[g-1];
        end

        swm_cell #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_sample (sample),
            .i_old    (r_old),
            .i_up_val (up_val),
            .i_up_vld (up_vld),
            .i_lo_val (lo_val),
            .i_lo_vld (lo_vld),
            .i_lo_gt  (lo_gt),
            .o_val    (c_val[g]),
            .o_vld    (c_vld[g]),
            .o_a_val  (c_a_val[g]),
            .o_a_vld  (c_a_vld[g]),
            .o_gt     (c_gt[g])
        );
    end

    // Median tap.
    always_comb begin
        med = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            if (midx == KW'(i)) begin
                med = c_val[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_pend <= result;
            end else if (move) begin
                r_pend <= 1'b0;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= med;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = DW'(r_out);

endmodule

// ===== src/swm_checker.sv =====
// Port-level checks for the sliding-window median filter, bound to its top level.
// Depends on swm_pkg for parameter defaults and on sliding_window_median_top.
module swm_checker #(
    parameter int WINDOW_MAX   = swm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready
);

    localparam int WMAX = WINDOW_MAX;

    // Hold a stalled output beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    // Reset drops any pending result.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // Input side only stalls behind a stalled output.
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled with output free");

    // A result needs a preceding input beat or an input stall.
    a_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) && WMAX > 0 |-> $past(i_rst_n, 2)
            && ($past(s_axis_tvalid && s_axis_tready, 2)
                || $past(!s_axis_tready, 1) || $past(!s_axis_tready, 2)))
        else $error("result without a preceding input beat");

    // Config port never stalls.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write stalled");

endmodule

bind sliding_window_median_top swm_checker #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_swm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready)
);

// ===== tb/swm_median_checker.sv =====
`timescale 1ns / 100ps
// Median scoreboard for sliding_window_median_top: watches the sample, size and median beats.
// Keeps its own window in arrival order and checks every median beat in order; uses swm_pkg.
module swm_median_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_smp_valid,
    input  logic                          i_smp_ready,
    input  logic [15:0]                   i_smp_data,
    input  logic                          i_smp_start,
    input  logic                          i_med_valid,
    input  logic                          i_med_ready,
    input  logic [15:0]                   i_med_data,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [swm_pkg::CFG_WIDTH-1:0] i_cfg_data,
    output int                            o_mismatch_count,
    output int                            o_medians_pending
);

    logic [15:0]                   window_q[$];
    logic [15:0]                   expected_medians[$];
    logic [swm_pkg::CFG_WIDTH-1:0] window_size = swm_pkg::WINDOW_SIZE_RESET;
    logic [15:0]                   want;
    int                            mismatches = 0;

    assign o_mismatch_count = mismatches;

    function automatic int span(input logic [swm_pkg::CFG_WIDTH-1:0] sz);
        if (sz == 0) return 1;
        if (sz > swm_pkg::WINDOW_MAX_DEF) return swm_pkg::WINDOW_MAX_DEF;
        return int'(sz);
    endfunction

    // lower median: the value whose rank range covers (n-1)/2
    function automatic logic [15:0] lower_median();
        int rank;
        int lt;
        int eq;
        rank = (window_q.size() - 1) / 2;
        for (int i = 0; i < window_q.size(); i++) begin
            lt = 0;
            eq = 0;
            for (int j = 0; j < window_q.size(); j++) begin
                if (window_q[j] < window_q[i]) lt++;
                else if (window_q[j] == window_q[i]) eq++;
            end
            if (lt <= rank && rank < lt + eq) return window_q[i];
        end
        return '0;
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] exp_v,
                                 input logic [15:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s median: expected %04h, got %04h", $realtime, what, exp_v, got_v);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_q.delete();
            expected_medians.delete();
            window_size = swm_pkg::WINDOW_SIZE_RESET;
        end else begin
            if (i_med_valid && i_med_ready) begin
                if (expected_medians.size() == 0) begin
                    flag_mismatch("unexpected", 16'h0000, i_med_data);
                end else begin
                    want = expected_medians.pop_front();
                    if (i_med_data !== want) flag_mismatch("wrong", want, i_med_data);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                window_size = i_cfg_data;
                window_q.delete();
            end
            if (i_smp_valid && i_smp_ready) begin
                if (i_smp_start) window_q.delete();
                window_q.push_back(i_smp_data);
                while (window_q.size() > span(window_size)) void'(window_q.pop_front());
                if (window_q.size() == span(window_size))
                    expected_medians.push_back(lower_median());
            end
        end
        o_medians_pending <= expected_medians.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the sliding-window median testbench: clock, reset, sample and size beats, verdict.
// Instantiates sliding_window_median_top and swm_median_checker; uses swm_pkg.
module tb_top;

    localparam int RUN_LIMIT    = 100000;
    localparam int DRAIN_CYCLES = 6;
    localparam int NUM_SEGMENTS = 12;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [15:0]                   s_axis_tdata  = '0;
    logic                          s_axis_tuser  = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [15:0]                   m_axis_tdata;
    logic                          i_cfg_valid   = 1'b0;
    logic                          o_cfg_ready;
    logic [swm_pkg::CFG_WIDTH-1:0] i_cfg_data    = '0;

    int mismatch_count;
    int medians_pending;
    int cycles      = 0;
    int tx_idle_pct = 6;
    int rx_idle_pct = 46;

    int sizes[NUM_SEGMENTS] = '{1, 64, 0, 127, 2, 5, 65, 8, 3, 16, 4, 33};

    always #5 i_clk = ~i_clk;

    sliding_window_median_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    swm_median_checker i_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_smp_valid       (s_axis_tvalid),
        .i_smp_ready       (s_axis_tready),
        .i_smp_data        (s_axis_tdata),
        .i_smp_start       (s_axis_tuser),
        .i_med_valid       (m_axis_tvalid),
        .i_med_ready       (m_axis_tready),
        .i_med_data        (m_axis_tdata),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_mismatch_count  (mismatch_count),
        .o_medians_pending (medians_pending)
    );

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(3))
            0: return 16'($urandom_range(7));
            1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [15:0] value, input logic start);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= start;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (medians_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(input int size);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= size[swm_pkg::CFG_WIDTH-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int k;
        int count;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset window of three: extremes, duplicates, restarts before and after fill
        send_sample(16'h0000, 1'b1);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h0001, 1'b0);
        send_sample(16'h0000, 1'b1);
        send_sample(16'h0007, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0002, 1'b0);
        send_sample(16'h0009, 1'b0);
        send_sample(16'h0009, 1'b0);

        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            write_window(sizes[seg]);
            tx_idle_pct = (seg < 4) ? 6 : (seg < 8) ? 46 : 0;
            rx_idle_pct = (seg < 4) ? 46 : (seg < 8) ? 6 : 0;
            k = (sizes[seg] == 0) ? 1 : (sizes[seg] > swm_pkg::WINDOW_MAX_DEF) ?
                swm_pkg::WINDOW_MAX_DEF : sizes[seg];
            count = (k > 30) ? k + 24 : 36;
            for (int n = 0; n < count; n++)
                send_sample(pick_sample(), $urandom_range(4 * k + 8) == 0);
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/swm_pkg.sv
src/swm_cell.sv
src/sliding_window_median_top.sv
src/swm_checker.sv
tb/swm_median_checker.sv
tb/tb_top.sv
